// ===== sv/bpm_pkg.sv =====
// Package for the breakpoint match unit: field widths, operation codes,
// banked address window and the controller-to-datapath command bundle.
// No dependencies.
`timescale 1ns / 1ps

package bpm_pkg;

  localparam int KIND_W   = 2;
  localparam int BANK_W   = 8;
  localparam int ADDR_W   = 16;
  localparam int COUNT_W  = 16;
  localparam int SLOT_W   = 4;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_SET     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLR_ALL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd3;

  // Addresses from BANKED_LO up to, but not including, BANKED_HI are banked.
  localparam logic [ADDR_W-1:0] BANKED_LO = 16'h4000;
  localparam logic [ADDR_W-1:0] BANKED_HI = 16'h8000;

  // Commands from the controller; at most one is active in any cycle.
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic match;     // compare the request with every slot
    logic select;    // keep only the lowest matching slot
    logic update;    // write the table and load the response register
  } bpm_cmd_t;

endpackage

// ===== sv/bpm_req_if.sv =====
// Request channel of the breakpoint match unit: handshake and request fields.
// Depends on bpm_pkg.
`timescale 1ns / 1ps

interface bpm_req_if
  import bpm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BANK_W-1:0]  bank;
  logic [ADDR_W-1:0]  addr;
  logic [COUNT_W-1:0] pass_count;

  modport source (output valid, output kind, output bank, output addr,
                  output pass_count, input ready);
  modport sink   (input valid, input kind, input bank, input addr,
                  input pass_count, output ready);
endinterface

// ===== sv/bpm_rsp_if.sv =====
// Response channel of the breakpoint match unit: handshake and result fields.
// Depends on bpm_pkg.
`timescale 1ns / 1ps

interface bpm_rsp_if
  import bpm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              full_res;

  modport source (output valid, output hit, output slot, output full_res,
                  input ready);
  modport sink   (input valid, input hit, input slot, input full_res,
                  output ready);
endinterface

// ===== sv/bpm_ctrl.sv =====
// Controller of the breakpoint match unit: sequences capture, match, select
// and update, and owns the response valid flag. Depends on bpm_pkg.
`timescale 1ns / 1ps

module bpm_ctrl
  import bpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output bpm_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_SELECT = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.match  = 1'b1;
        state_next = ST_SELECT;
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // Hold here until the response register can take the new result.
        if (out_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    priority if (cmd.update) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/bpm_datapath.sv =====
// Datapath of the breakpoint match unit: the slot table, per-slot comparators,
// lowest-slot selection and the response register. Depends on bpm_pkg.
`timescale 1ns / 1ps

module bpm_datapath
  import bpm_pkg::*;
#(
  parameter int SLOTS = 16
)(
  input  logic               clk,
  input  logic               rst,
  input  bpm_cmd_t           cmd,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [BANK_W-1:0]  in_bank,
  input  logic [ADDR_W-1:0]  in_addr,
  input  logic [COUNT_W-1:0] in_count,
  output logic               hit,
  output logic [SLOT_W-1:0]  slot,
  output logic               full_res
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Latched request.
  logic [KIND_W-1:0]  req_kind;
  logic [BANK_W-1:0]  req_bank;
  logic [ADDR_W-1:0]  req_addr;
  logic [COUNT_W-1:0] req_count;

  // Slot table.
  logic [SLOTS-1:0]   slot_used;
  logic [BANK_W-1:0]  slot_bank  [SLOTS];
  logic [ADDR_W-1:0]  slot_addr  [SLOTS];
  logic [COUNT_W-1:0] slot_count [SLOTS];

  logic [SLOTS-1:0]   match_vec;
  logic [SLOTS-1:0]   match_next;
  logic [SLOTS-1:0]   sel_vec;
  logic               any_match;
  logic [SLOTS-1:0]   cnt_one;
  logic [IDX_W-1:0]   sel_idx;
  logic [IDX_W+SLOT_W-1:0] sel_idx_ext;
  logic               banked;
  logic               fire;

  assign banked = (req_addr >= BANKED_LO) && (req_addr < BANKED_HI);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      unique case (req_kind)
        KIND_SET:     match_next[i] = !slot_used[i];
        KIND_CLEAR:   match_next[i] = slot_used[i] && (slot_addr[i] == req_addr)
                                      && (slot_bank[i] == req_bank);
        KIND_CLR_ALL: match_next[i] = 1'b0;
        KIND_CHECK:   match_next[i] = slot_used[i] && (slot_addr[i] == req_addr)
                                      && (!banked || (slot_bank[i] == req_bank));
        default:      match_next[i] = 1'b0;
      endcase
      cnt_one[i] = (slot_count[i] == COUNT_W'(1));
    end
  end

  // Encode the one-hot selection into a slot index.
  always_comb begin
    sel_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel_vec[i]) begin
        sel_idx = sel_idx | IDX_W'(i);
      end
    end
  end

  assign sel_idx_ext = {{SLOT_W{1'b0}}, sel_idx};
  assign fire        = |(sel_vec & cnt_one);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind  <= in_kind;
      req_bank  <= in_bank;
      req_addr  <= in_addr;
      req_count <= in_count;
    end
    if (cmd.match) begin
      match_vec <= match_next;
    end
    if (cmd.select) begin
      // Isolate the lowest set bit.
      sel_vec   <= match_vec & (~match_vec + SLOTS'(1));
      any_match <= |match_vec;
    end
    if (cmd.update) begin
      hit      <= 1'b0;
      slot     <= '0;
      full_res <= 1'b0;
      unique case (req_kind)
        KIND_SET: begin
          full_res <= !any_match;
          slot     <= sel_idx_ext[SLOT_W-1:0];
        end
        KIND_CHECK: begin
          hit <= fire;
          if (fire) begin
            slot <= sel_idx_ext[SLOT_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_bank[i]  <= '0;
        slot_addr[i]  <= '0;
        slot_count[i] <= '0;
      end
    end else if (cmd.update) begin
      for (int i = 0; i < SLOTS; i++) begin
        unique case (req_kind)
          KIND_SET: begin
            if (sel_vec[i]) begin
              slot_used[i]  <= 1'b1;
              slot_bank[i]  <= req_bank;
              slot_addr[i]  <= req_addr;
              slot_count[i] <= req_count;
            end
          end
          KIND_CLEAR: begin
            if (match_vec[i]) begin
              slot_used[i] <= 1'b0;
            end
          end
          KIND_CLR_ALL: begin
            slot_used[i]  <= 1'b0;
            slot_bank[i]  <= '0;
            slot_addr[i]  <= '0;
            slot_count[i] <= '0;
          end
          KIND_CHECK: begin
            // A count of zero never fires and stays as it is.
            if (sel_vec[i] && (slot_count[i] != '0)) begin
              slot_count[i] <= slot_count[i] - COUNT_W'(1);
              if (cnt_one[i]) begin
                slot_used[i] <= 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/breakpoint_match_unit_top.sv =====
// Breakpoint match unit, top level. A request transaction is followed by the
// match, select and update steps; the response becomes valid after the update
// step, which waits for a free response register. One request at a time.
// A waiting response does not block the next request until its update step.
// Reset (rst, synchronous, active high) empties the table and the response.
// Depends on bpm_pkg, bpm_req_if, bpm_rsp_if, bpm_ctrl and bpm_datapath.
`timescale 1ns / 1ps

module breakpoint_match_unit_top
  import bpm_pkg::*;
#(
  parameter int SLOTS = 16
)(
  input  logic      clk,
  input  logic      rst,
  bpm_req_if.sink   req,
  bpm_rsp_if.source rsp
);

  // The controller steps through four states per request: it accepts the
  // transaction, lets the datapath compare it against every slot in parallel,
  // narrows the matches down to the lowest slot, and finally writes the
  // table and the response register together.
  bpm_cmd_t          cmd;
  logic              rsp_valid;
  logic              dp_hit;
  logic [SLOT_W-1:0] dp_slot;
  logic              dp_full;

  bpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp_valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // The datapath holds one comparator per slot, so each slot is read only
  // at its own place; the lowest match is isolated with a single add.
  bpm_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_kind  (req.kind),
    .in_bank  (req.bank),
    .in_addr  (req.addr),
    .in_count (req.pass_count),
    .hit      (dp_hit),
    .slot     (dp_slot),
    .full_res (dp_full)
  );

  // The result fields come straight from the datapath's output register.
  assign rsp.valid    = rsp_valid;
  assign rsp.hit      = dp_hit;
  assign rsp.slot     = dp_slot;
  assign rsp.full_res = dp_full;

  // The table must never be written while an untaken response would be lost.
  a_update_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (!rsp_valid || rsp.ready))
    else $error("update issued while the response register is occupied");

  // A fresh response appears only after an update step.
  a_rsp_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.update))
    else $error("response became valid without an update");

  // A hit comes from a check and a full flag from a set, never both.
  a_hit_full_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(dp_hit && dp_full))
    else $error("hit and full reported together");

  // No new request is taken in the cycle after one has been accepted.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request accepted while one is in progress");

endmodule
